// ----- sv/bsd_pkg.sv -----
`default_nettype none
package bsd_pkg;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerA    = 8'h61;
  localparam logic [7:0] CharLowerB    = 8'h62;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharLowerV    = 8'h76;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharLowerX    = 8'h78;

  localparam logic [1:0] OctDigitsMax = 2'd3;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEsc    = 2'd1,
    ModeOct    = 2'd2,
    ModeHex    = 2'd3
  } decode_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } bsd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_string_end;
  } bsd_out_t;

  // One classified input: one or two decoded bytes
  typedef struct packed {
    logic       pair;
    logic [7:0] first;
    logic [7:0] second;
    logic       last;
  } bsd_entry_t;

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h37);
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Control byte for a simple escape, otherwise the byte itself
  function automatic logic [7:0] simple_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CharLowerN: r = 8'd10;
      CharLowerT: r = 8'd9;
      CharLowerA: r = 8'd7;
      CharLowerB: r = 8'd8;
      CharLowerR: r = 8'd13;
      CharLowerV: r = 8'd11;
      CharLowerF: r = 8'd12;
      default:    r = b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/bsd_front.sv -----
`default_nettype none
module bsd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire bsd_pkg::bsd_in_t in_data_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output bsd_pkg::bsd_entry_t   q_entry_o
);
  import bsd_pkg::*;

  decode_mode_e mode_q, mode_d;
  logic [7:0]   accum_q, accum_d;
  logic [1:0]   count_q, count_d;
  logic [1:0]   n_res;
  logic [7:0]   b;
  logic         last;
  logic         take;
  logic [7:0]   acc_oct, acc_hex;
  logic [4:0]   hd;
  logic [1:0]   cnt_inc;

  assign b          = in_data_i.in_byte;
  assign last       = in_data_i.in_last;
  assign in_stall_o = q_full_i;
  assign take       = in_valid_i && !q_full_i;
  assign hd         = hex_digit(b);
  assign acc_oct    = {accum_q[4:0], b[2:0]};
  assign acc_hex    = {accum_q[3:0], hd[3:0]};
  assign cnt_inc    = count_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      accum_q <= 8'd0;
      count_q <= 2'd0;
    end else if (take) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    mode_d           = mode_q;
    accum_d          = accum_q;
    count_d          = count_q;
    n_res            = 2'd0;
    q_entry_o.first  = b;
    q_entry_o.second = b;
    case (mode_q)
      ModeNormal: begin
        if (b == CharBackslash && !last) begin
          mode_d = ModeEsc;
        end else begin
          n_res = 2'd1;
        end
      end
      ModeEsc: begin
        mode_d = ModeNormal;
        if (b == CharLowerX) begin
          accum_d = 8'd0;
          count_d = 2'd0;
          q_entry_o.first = 8'd0;
          if (last) n_res = 2'd1;
          else mode_d = ModeHex;
        end else if (is_octal(b)) begin
          accum_d = {5'd0, b[2:0]};
          count_d = 2'd1;
          q_entry_o.first = {5'd0, b[2:0]};
          if (last) n_res = 2'd1;
          else mode_d = ModeOct;
        end else begin
          q_entry_o.first = simple_escape(b);
          n_res = 2'd1;
        end
      end
      ModeOct, ModeHex: begin
        if ((mode_q == ModeOct && is_octal(b)) || (mode_q == ModeHex && hd[4])) begin
          accum_d = (mode_q == ModeOct) ? acc_oct : acc_hex;
          count_d = cnt_inc;
          q_entry_o.first = accum_d;
          if (last || (mode_q == ModeOct && cnt_inc == OctDigitsMax) ||
              (mode_q == ModeHex && cnt_inc[1])) begin
            mode_d = ModeNormal;
            n_res  = 2'd1;
          end
        end else begin
          // flush the pending value; byte is text or starts an escape
          q_entry_o.first = accum_q;
          if (b == CharBackslash && !last) begin
            mode_d = ModeEsc;
            n_res  = 2'd1;
          end else begin
            mode_d = ModeNormal;
            n_res  = 2'd2;
          end
        end
      end
      default: mode_d = ModeNormal;
    endcase
    q_entry_o.pair = (n_res == 2'd2);
    q_entry_o.last = last;
  end

  assign q_push_o = take && (n_res != 2'd0);

endmodule
`default_nettype wire

// ----- sv/bsd_queue.sv -----
`default_nettype none
module bsd_queue #(
  parameter int Depth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire bsd_pkg::bsd_entry_t push_entry_i,
  input  wire logic                pop_i,
  output bsd_pkg::bsd_entry_t      head_o,
  output logic                     empty_o,
  output logic                     full_o
);
  import bsd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bsd_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- sv/bsd_back.sv -----
`default_nettype none
module bsd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bsd_pkg::bsd_entry_t head_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bsd_pkg::bsd_out_t        out_data_o
);
  import bsd_pkg::*;

  logic     out_valid_q, out_valid_d;
  bsd_out_t out_q, out_d;
  logic     second_q, second_d;
  logic     load;

  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    second_d    = second_q;
    pop_o       = 1'b0;
    if (load) begin
      if (second_q) begin
        out_valid_d = 1'b1;
        out_d       = '{out_byte: head_i.second, out_run_last: 1'b1,
                        out_string_end: head_i.last};
        second_d    = 1'b0;
        pop_o       = 1'b1;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        out_d       = '{out_byte: head_i.first, out_run_last: !head_i.pair,
                        out_string_end: head_i.last && !head_i.pair};
        second_d    = head_i.pair;
        pop_o       = !head_i.pair;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_second_has_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !empty_i) else $error("second byte pending with empty queue");
  a_pair_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.out_run_last) |=>
    (out_valid_o && out_data_o.out_run_last))
    else $error("second byte of a pair did not follow");
  a_hold_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output transaction changed");

endmodule
`default_nettype wire

// ----- sv/backslash_escape_decoder.sv -----
`default_nettype none
// Backslash escape decoder. Takes one raw string byte per transaction (with a
// flag on the string's last byte) and returns the decoded bytes: the simple
// escapes \n \t \\ \a \b \r \v \f, octal escapes of one to three digits
// (wrapping modulo 256) and \x with up to two hex digits (zero when no digit
// follows). Any other escaped byte comes out as itself, and a backslash that
// ends the string comes out literally. An input transaction yields zero, one
// or two output transactions; out_run_last marks the last one caused by an
// input and out_string_end marks the final decoded byte of a string. Every
// input with the last flag set yields at least one output. Input is taken at
// one byte per cycle: the decoder front classifies each byte in the cycle it
// arrives and places its results in a QueueDepth-entry queue. The back end
// drains that queue through a registered output at one byte per cycle while
// the output is not stalled, so a two-byte result leaves as two successive
// output transactions, and input stalls only when the queue is full.
module backslash_escape_decoder #(
  parameter int QueueDepth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire bsd_pkg::bsd_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output bsd_pkg::bsd_out_t     out_data_o
);
  import bsd_pkg::*;

  bsd_entry_t push_entry, head;
  logic       push, pop, q_empty, q_full;

  // Front: decode state machine, one classified transaction per cycle while the queue is not full
  bsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_entry_o  (push_entry)
  );

  // Queue: decouple the front from output back-pressure
  bsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  // Back: serialise each entry into one or two output transactions
  bsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
